// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helper functions of the stuffed frame receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // framing bytes
    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // payload limit and counter width
    localparam int MAX_PAYLOAD = 256;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    // result field widths
    localparam int LEN_W   = 9;
    localparam int LEN_SAT = (1 << LEN_W) - 1;

    // output queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // configuration port
    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_ADDRESS    = 2'd0,
        REG_INFO_CTRL  = 2'd1,
        REG_DISC_CTRL  = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_HUNT    = 3'd0,
        ST_FLAG    = 3'd1,
        ST_ADDR    = 3'd2,
        ST_CTRL    = 3'd3,
        ST_PAYLOAD = 3'd4
    } hunt_state_t;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_DISC = 2'd3
    } kind_t;

    typedef struct packed {
        logic             esc;
        logic             held_valid;
        logic [7:0]       held_byte;
        logic [7:0]       check;
        logic [CNT_W-1:0] count;
        logic             too_long;
    } frame_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic [LEN_W-1:0] frame_length;
        logic             is_last;
    } result_t;

    // saturate the payload count to the length field
    function automatic logic [LEN_W-1:0] sat_len(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        if (wide > 32'(LEN_SAT)) begin
            return LEN_W'(LEN_SAT);
        end
        return wide[LEN_W-1:0];
    endfunction

    function automatic result_t data_result(input logic [7:0] d);
        result_t r;
        r.kind         = KIND_DATA;
        r.out_byte     = d;
        r.frame_length = '0;
        r.is_last      = 1'b0;
        return r;
    endfunction

    function automatic result_t verdict_result(input logic good,
                                               input logic [CNT_W-1:0] cnt);
        result_t r;
        r.kind         = good ? KIND_GOOD : KIND_BAD;
        r.out_byte     = '0;
        r.frame_length = sat_len(cnt);
        r.is_last      = 1'b0;
        return r;
    endfunction

    function automatic result_t disc_result();
        result_t r;
        r.kind         = KIND_DISC;
        r.out_byte     = '0;
        r.frame_length = '0;
        r.is_last      = 1'b0;
        return r;
    endfunction

    // take one destuffed byte, release the held one if within the limit
    function automatic void push_data(input frame_t f, input logic [7:0] d,
                                      output frame_t fo, output logic emit);
        fo   = f;
        emit = 1'b0;
        if (f.held_valid) begin
            if (f.count < CNT_MAX) begin
                emit     = 1'b1;
                fo.check = f.check ^ f.held_byte;
                fo.count = f.count + 1'b1;
            end else begin
                fo.too_long = 1'b1;
            end
        end
        fo.held_byte  = d;
        fo.held_valid = 1'b1;
    endfunction

endpackage

// ===== rtl/stuffed_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit
// Byte-stuffed frame deframer with XOR block check, one raw byte per beat.
// ----------------------------------------------------------------------------
// Raw line bytes come in on the s_ stream, one byte per beat. The unit hunts
// for flag, address, control and BCC1 (address XOR control), reports a
// disconnect control byte at once, then destuffs the payload and streams each
// byte out one byte late, so the byte before the closing flag is kept back as
// BCC2 and checked against the XOR of the delivered bytes. A verdict beat
// (good or bad, with the delivered length) ends every frame; frames over the
// payload limit are truncated and reported bad. An input beat is taken every
// cycle while the four-entry output queue has room for two results; results
// are written into the output queue registers and leave on m_ from its head,
// one beat per cycle while m_tready is high. A byte that causes two results
// (an unknown escape, or a closing flag after a pending escape) fills two
// queue entries and can hold the input back. m_tlast marks the last result
// caused by one input byte. Register writes take effect at once, also in
// mid-frame.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit
    import sfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,

    // input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,     // [7:0] rx_byte

    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [23:0]        m_tdata,     // [7:0] out_byte, [16:8] frame_length
    output logic [1:0]         m_tuser,     // [1:0] kind
    output logic               m_tlast,     // is_last

    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // configuration registers
    logic [7:0] address_reg;
    logic [7:0] info_ctrl_reg;
    logic [7:0] disc_ctrl_reg;

    // deframer state
    hunt_state_t state_reg, state_next;
    frame_t      frame_reg, frame_next;

    // output queue
    result_t             queue_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg,  count_next;

    logic        s_fire;
    logic        m_fire;
    logic        cfg_write;
    reg_index_t  cfg_index;
    logic [7:0]  rx_byte;

    // up to two results per byte, in order: slot a then slot b
    logic        a_valid, b_valid;
    result_t     a_res,   b_res;
    frame_t      fa, fb;
    logic        ea, eb;
    logic        good;

    // queue write plan
    logic [1:0]  n_push;
    result_t     w0_res, w1_res;
    result_t     head;

    assign rx_byte   = s_tdata;
    assign s_tready  = (count_reg <= QCNT_W'(QDEPTH - 2));
    assign s_fire    = s_tvalid & s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign m_fire    = m_tvalid & m_tready;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[PADDR_W-1:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_reg   <= 8'd3;
            info_ctrl_reg <= 8'd0;
            disc_ctrl_reg <= 8'd11;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_ADDRESS:   address_reg   <= pwdata[7:0];
                REG_INFO_CTRL: info_ctrl_reg <= pwdata[7:0];
                REG_DISC_CTRL: disc_ctrl_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_ADDRESS:   prdata = {24'd0, address_reg};
            REG_INFO_CTRL: prdata = {24'd0, info_ctrl_reg};
            REG_DISC_CTRL: prdata = {24'd0, disc_ctrl_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------- deframer ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_HUNT;
            frame_reg <= '0;
        end else begin
            state_reg <= state_next;
            frame_reg <= frame_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        frame_next = frame_reg;
        a_valid    = 1'b0;
        b_valid    = 1'b0;
        a_res      = data_result(frame_reg.held_byte);
        b_res      = disc_result();
        fa         = frame_reg;
        fb         = frame_reg;
        ea         = 1'b0;
        eb         = 1'b0;
        good       = 1'b0;

        if (s_fire) begin
            if (state_reg == ST_PAYLOAD) begin
                if (rx_byte == FLAG_BYTE) begin
                    // closing flag; a pending escape is a literal data byte
                    if (frame_reg.esc) begin
                        push_data(frame_reg, ESC_BYTE, fa, ea);
                        fa.esc = 1'b0;
                    end
                    good    = fa.held_valid & ~fa.too_long & (fa.check == fa.held_byte);
                    a_valid = ea;
                    b_valid = 1'b1;
                    b_res   = verdict_result(good, fa.count);
                    // closing flag doubles as the next opening flag
                    frame_next = '0;
                    state_next = ST_FLAG;
                end else if (frame_reg.esc) begin
                    push_data(frame_reg, (rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE,
                              fa, ea);
                    fa.esc     = 1'b0;
                    a_valid    = ea;
                    frame_next = fa;
                    if (rx_byte != ESC_FLAG && rx_byte != ESC_ESC) begin
                        // unknown escape: literal escape byte, then this byte afresh
                        if (rx_byte == ESC_BYTE) begin
                            frame_next.esc = 1'b1;
                        end else begin
                            push_data(fa, rx_byte, fb, eb);
                            b_valid    = eb;
                            b_res      = data_result(fa.held_byte);
                            frame_next = fb;
                        end
                    end
                end else if (rx_byte == ESC_BYTE) begin
                    frame_next.esc = 1'b1;
                end else begin
                    push_data(frame_reg, rx_byte, fa, ea);
                    a_valid    = ea;
                    frame_next = fa;
                end
            end else if (rx_byte == FLAG_BYTE) begin
                state_next = ST_FLAG;
            end else begin
                unique case (state_reg)
                    ST_FLAG: begin
                        state_next = (rx_byte == address_reg) ? ST_ADDR : ST_HUNT;
                    end
                    ST_ADDR: begin
                        // info control wins when both registers match
                        if (rx_byte == info_ctrl_reg) begin
                            state_next = ST_CTRL;
                        end else if (rx_byte == disc_ctrl_reg) begin
                            b_valid    = 1'b1;
                            b_res      = disc_result();
                            state_next = ST_HUNT;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                    ST_CTRL: begin
                        if (rx_byte == (address_reg ^ info_ctrl_reg)) begin
                            frame_next = '0;
                            state_next = ST_PAYLOAD;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                    default: begin
                        state_next = ST_HUNT;
                    end
                endcase
            end
        end
    end

    // ---------------- output queue ----------------
    always_comb begin
        w0_res = a_valid ? a_res : b_res;
        w1_res = b_res;
        if (a_valid && b_valid) begin
            n_push         = 2'd2;
            w0_res.is_last = 1'b0;
            w1_res.is_last = 1'b1;
        end else if (a_valid || b_valid) begin
            n_push         = 2'd1;
            w0_res.is_last = 1'b1;
        end else begin
            n_push = 2'd0;
        end

        wr_ptr_next = wr_ptr_reg + QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + QPTR_W'(m_fire);
        count_next  = count_reg + QCNT_W'(n_push) - QCNT_W'(m_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue entries carry payload only
    always_ff @(posedge aclk) begin
        if (n_push != 2'd0) begin
            queue_reg[wr_ptr_reg] <= w0_res;
        end
        if (n_push == 2'd2) begin
            queue_reg[wr_ptr_reg + 1'b1] <= w1_res;
        end
    end

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {7'd0, head.frame_length, head.out_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.is_last;

endmodule

// ===== tb/sv/stuffed_frame_receiver_unit_test.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_receiver_unit_test
// Self-checking bench for the byte-stuffed frame deframer.
// ----------------------------------------------------------------------------
// Raw line bytes are fed on the s_ stream. A short hand-written line walks
// through empty, good and escaped frames, a disconnect and broken headers.
// Random traffic follows: mostly well-formed frames with random payload,
// stuffing and the odd fault, plus disconnects, broken headers and noise,
// under several address and control settings. A byte-level deframer model
// inside the bench predicts every result beat, and each beat on the m_
// stream is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module stuffed_frame_receiver_unit_test;
    import sfr_pkg::*;

    localparam int IDLE_LIMIT    = 500;  // cycles with no beat on any port
    localparam int SETTLE_CYCLES = 8;    // quiet time before register writes
    localparam int PHASE_BYTES   = 32;   // random line bytes per setting
    localparam int LONG_PAYLOAD  = MAX_PAYLOAD + 1;

    // one predicted or observed result beat
    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic [8:0] len;
        logic       last;
    } beat_t;

    // how much of a directed row's outcome is typed in by hand
    typedef enum int {
        OPEN_ROW,   // left to the deframer model
        NO_BEAT,    // byte must cause nothing
        ONE_BEAT    // byte must cause exactly the given verdict or disconnect
    } row_check_t;

    typedef struct {
        logic [7:0] rx;
        row_check_t check;
        kind_t      kind;
        logic [8:0] len;
    } plan_row_t;

    // clock, reset and ports
    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = '0;      // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;            // [7:0] out_byte, [16:8] frame_length
    logic [1:0]         m_tuser;            // [1:0] kind
    logic               m_tlast;            // is_last
    logic               psel     = 1'b0;
    logic               penable  = 1'b0;
    logic               pwrite   = 1'b0;
    logic [PADDR_W-1:0] paddr    = '0;
    logic [31:0]        pwdata   = '0;
    logic [31:0]        prdata;
    logic               pready;

    stuffed_frame_receiver_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // deframer model: register copies and per-frame state
    // ------------------------------------------------------------------
    logic [7:0]  cfg_address = 8'h03;
    logic [7:0]  cfg_info    = 8'h00;
    logic [7:0]  cfg_disc    = 8'h0B;

    hunt_state_t rx_state    = ST_HUNT;
    logic        esc_pending = 1'b0;
    logic        held_ok     = 1'b0;
    logic [7:0]  held        = '0;
    logic [7:0]  check       = '0;
    int unsigned delivered   = 0;
    logic        overflow    = 1'b0;

    beat_t       step_beats[$];     // beats caused by the latest byte
    beat_t       awaited_beats[$];  // predicted beats not yet seen on m_

    // bookkeeping
    int          mismatch_count = 0;
    int          bytes_sent     = 0;
    int          beats_seen     = 0;
    int          good_frames    = 0;
    int          bad_frames     = 0;
    int          disconnects    = 0;
    int          reg_writes     = 0;
    int          idle_cycles    = 0;
    logic [7:0]  last_sent      = '0;
    bit          tx_calm        = 1'b0;  // sender runs without gaps
    bit          rx_calm        = 1'b0;  // receiver runs without stalls
    logic [7:0]  line_q[$];              // raw bytes queued for the line
    plan_row_t   plan[$];

    function automatic void note_mismatch(string msg);
        if (mismatch_count < 10) begin
            $display("mismatch: %s", msg);
        end
        mismatch_count++;
    endfunction

    function automatic void add_beat(kind_t k, logic [7:0] d, int unsigned len);
        beat_t r;
        r.kind = k;
        r.data = d;
        r.len  = (len > 511) ? 9'd511 : len[8:0];
        r.last = 1'b0;
        step_beats.push_back(r);
    endfunction

    function automatic void open_frame();
        esc_pending = 1'b0;
        held_ok     = 1'b0;
        held        = '0;
        check       = '0;
        delivered   = 0;
        overflow    = 1'b0;
    endfunction

    // hold the new byte back, release the previous one while under the limit
    function automatic void take_data(logic [7:0] d);
        if (held_ok) begin
            if (delivered < MAX_PAYLOAD) begin
                add_beat(KIND_DATA, held, 0);
                check = check ^ held;
                delivered++;
            end else begin
                overflow = 1'b1;
            end
        end
        held    = d;
        held_ok = 1'b1;
    endfunction

    // advance the model by one raw byte, queue what it produces
    function automatic void deframe_byte(logic [7:0] b);
        step_beats.delete();
        if (rx_state == ST_PAYLOAD) begin
            if (b == FLAG_BYTE) begin
                // a pending escape right before the flag is a literal escape byte
                if (esc_pending) begin
                    esc_pending = 1'b0;
                    take_data(ESC_BYTE);
                end
                // held byte is the block check; no held byte means empty frame
                add_beat((held_ok && !overflow && check == held) ? KIND_GOOD : KIND_BAD,
                         8'h00, delivered);
                open_frame();
                rx_state = ST_FLAG;     // closing flag doubles as opening flag
            end else if (esc_pending) begin
                esc_pending = 1'b0;
                if (b == ESC_FLAG) begin
                    take_data(FLAG_BYTE);
                end else if (b == ESC_ESC) begin
                    take_data(ESC_BYTE);
                end else begin
                    // unknown escape: literal escape, then this byte afresh
                    take_data(ESC_BYTE);
                    if (b == ESC_BYTE) begin
                        esc_pending = 1'b1;
                    end else begin
                        take_data(b);
                    end
                end
            end else if (b == ESC_BYTE) begin
                esc_pending = 1'b1;
            end else begin
                take_data(b);
            end
        end else if (b == FLAG_BYTE) begin
            // flag wins over any register match in the header
            rx_state = ST_FLAG;
        end else begin
            case (rx_state)
                ST_FLAG: begin
                    rx_state = (b == cfg_address) ? ST_ADDR : ST_HUNT;
                end
                ST_ADDR: begin
                    // info control wins when both controls are equal
                    if (b == cfg_info) begin
                        rx_state = ST_CTRL;
                    end else if (b == cfg_disc) begin
                        add_beat(KIND_DISC, 8'h00, 0);
                        rx_state = ST_HUNT;
                    end else begin
                        rx_state = ST_HUNT;
                    end
                end
                ST_CTRL: begin
                    if (b == (cfg_address ^ cfg_info)) begin
                        open_frame();
                        rx_state = ST_PAYLOAD;
                    end else begin
                        rx_state = ST_HUNT;
                    end
                end
                default: begin
                    rx_state = ST_HUNT;
                end
            endcase
        end
        if (step_beats.size() > 0) begin
            step_beats[step_beats.size() - 1].last = 1'b1;
        end
        foreach (step_beats[i]) begin
            awaited_beats.push_back(step_beats[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // line side: one raw byte per beat, random gap before each
    // ------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        // beat taken at this edge
        deframe_byte(b);
        last_sent = b;
        bytes_sent++;
    endtask

    task automatic send_line();
        foreach (line_q[i]) begin
            send_byte(line_q[i]);
        end
        line_q.delete();
    endtask

    function automatic void put_stuffed(logic [7:0] d);
        if (d == FLAG_BYTE) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(ESC_FLAG);
        end else if (d == ESC_BYTE) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(ESC_ESC);
        end else begin
            line_q.push_back(d);
        end
    endfunction

    // information frame with n data bytes; n of zero gives an empty frame
    task automatic send_info_frame(int n);
        logic [7:0] d;
        logic [7:0] bcc;
        int         odd_pos;
        // skip the opening flag at times: the last closing flag opens too
        if (last_sent != FLAG_BYTE || $urandom_range(0, 1) == 0) begin
            line_q.push_back(FLAG_BYTE);
        end
        line_q.push_back(cfg_address);
        line_q.push_back(cfg_info);
        line_q.push_back(cfg_address ^ cfg_info);
        bcc     = '0;
        odd_pos = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n) : -1;
        for (int i = 0; i < n; i++) begin
            // lean on the framing values so stuffing gets exercised hard
            case ($urandom_range(0, 7))
                0:       d = FLAG_BYTE;
                1:       d = ESC_BYTE;
                2:       d = ($urandom_range(0, 1) == 0) ? ESC_FLAG : ESC_ESC;
                default: d = 8'($urandom_range(0, 255));
            endcase
            // an escape that is neither of the two known ones
            if (i == odd_pos) begin
                line_q.push_back(ESC_BYTE);
                do d = 8'($urandom_range(0, 255));
                while (d == ESC_FLAG || d == ESC_ESC || d == FLAG_BYTE);
                line_q.push_back(d);
            end else begin
                bcc = bcc ^ d;
                put_stuffed(d);
            end
        end
        if (n > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                bcc = bcc ^ 8'($urandom_range(1, 255));
            end
            put_stuffed(bcc);
            // dangling escape in front of the closing flag
            if ($urandom_range(0, 19) == 0) begin
                line_q.push_back(ESC_BYTE);
            end
        end
        line_q.push_back(FLAG_BYTE);
    endtask

    task automatic send_random_unit();
        int pick;
        pick    = $urandom_range(0, 99);
        tx_calm = ($urandom_range(0, 4) == 0);
        if (pick < 60) begin
            send_info_frame(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                       : $urandom_range(1, 12));
        end else if (pick < 67) begin
            send_info_frame(0);
        end else if (pick < 79) begin
            line_q.push_back(FLAG_BYTE);
            line_q.push_back(cfg_address);
            line_q.push_back(cfg_disc);
        end else if (pick < 90) begin
            // header broken at a random point
            line_q.push_back(FLAG_BYTE);
            case ($urandom_range(0, 2))
                0: begin
                    line_q.push_back(8'($urandom_range(0, 255)));
                end
                1: begin
                    line_q.push_back(cfg_address);
                    line_q.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    line_q.push_back(cfg_address);
                    line_q.push_back(cfg_info);
                    line_q.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end else begin
            // line noise
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        send_line();
    endtask

    // ------------------------------------------------------------------
    // configuration port: setup cycle, then access cycle
    // ------------------------------------------------------------------
    task automatic write_reg(reg_index_t idx, logic [7:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= {24'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ADDRESS:   cfg_address = v;
            REG_INFO_CTRL: cfg_info    = v;
            REG_DISC_CTRL: cfg_disc    = v;
            default:       ;
        endcase
        reg_writes++;
    endtask

    // stop the line and let the unit drain
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_beats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic add_row(logic [7:0] rx, row_check_t chk, kind_t k, int len);
        plan_row_t r;
        r.rx    = rx;
        r.check = chk;
        r.kind  = k;
        r.len   = 9'(len);
        plan.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // result side: random stall before each beat, checked on handshake
    // ------------------------------------------------------------------
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            if ($urandom_range(0, 19) == 0) begin
                rx_calm = !rx_calm;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        beat_t got;
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind = kind_t'(m_tuser);
            got.data = m_tdata[7:0];
            got.len  = m_tdata[16:8];
            got.last = m_tlast;
            beats_seen++;
            case (got.kind)
                KIND_GOOD: good_frames++;
                KIND_BAD:  bad_frames++;
                KIND_DISC: disconnects++;
                default:   ;
            endcase
            if (awaited_beats.size() == 0) begin
                note_mismatch($sformatf("unexpected beat kind %0d byte %h len %0d last %b",
                                        got.kind, got.data, got.len, got.last));
            end else begin
                want = awaited_beats.pop_front();
                if (got.kind !== want.kind || got.data !== want.data ||
                    got.len !== want.len || got.last !== want.last) begin
                    note_mismatch($sformatf(
                        "beat %0d: want kind %0d byte %h len %0d last %b, got %0d %h %0d %b",
                        beats_seen, want.kind, want.data, want.len, want.last,
                        got.kind, got.data, got.len, got.last));
                end
            end
        end
    end

    // watchdog: any beat on either stream or a register access counts as progress
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no progress for %0d cycles, %0d beats still awaited",
                     IDLE_LIMIT, awaited_beats.size());
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        // settings walked after the reset one: extremes, equal controls, random
        logic [7:0] set_address[4];
        logic [7:0] set_info[4];
        logic [7:0] set_disc[4];
        int         phase_end;

        set_address = '{8'hFF, 8'h00, 8'h80, 8'h00};
        set_info    = '{8'hFF, 8'h5A, 8'h00, 8'h00};
        set_disc    = '{8'h00, 8'h5A, 8'hFF, 8'h00};
        set_address[3] = 8'($urandom_range(0, 255));
        set_info[3]    = 8'($urandom_range(0, 255));
        set_disc[3]    = 8'($urandom_range(0, 255));
        if (set_address[3] == FLAG_BYTE) set_address[3] = 8'h01;
        if (set_info[3] == FLAG_BYTE) set_info[3] = 8'h02;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed line under the reset settings (address 03, info 00, disc 0B)
        // empty frame, its closing flag opens the next one
        add_row(FLAG_BYTE, NO_BEAT, KIND_DATA, 0);
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h00, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(FLAG_BYTE, ONE_BEAT, KIND_BAD, 0);
        // good frame 12 34 with check 26
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h00, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h12, NO_BEAT, KIND_DATA, 0);
        add_row(8'h34, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h26, OPEN_ROW, KIND_DATA, 0);
        add_row(FLAG_BYTE, ONE_BEAT, KIND_GOOD, 2);
        // escaped flag, unknown escape, escape chain, escape before the flag
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h00, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(ESC_BYTE, OPEN_ROW, KIND_DATA, 0);
        add_row(ESC_FLAG, OPEN_ROW, KIND_DATA, 0);
        add_row(ESC_BYTE, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h41, OPEN_ROW, KIND_DATA, 0);
        add_row(ESC_BYTE, OPEN_ROW, KIND_DATA, 0);
        add_row(ESC_BYTE, OPEN_ROW, KIND_DATA, 0);
        add_row(FLAG_BYTE, OPEN_ROW, KIND_DATA, 0);
        // disconnect right after the shared flag
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h0B, ONE_BEAT, KIND_DISC, 0);
        // flag inside the header, then a wrong address
        add_row(FLAG_BYTE, OPEN_ROW, KIND_DATA, 0);
        add_row(8'h03, OPEN_ROW, KIND_DATA, 0);
        add_row(FLAG_BYTE, NO_BEAT, KIND_DATA, 0);
        add_row(8'hFF, NO_BEAT, KIND_DATA, 0);

        foreach (plan[i]) begin
            send_byte(plan[i].rx);
            if (plan[i].check == NO_BEAT && step_beats.size() != 0) begin
                note_mismatch($sformatf("directed row %0d: model gives %0d beats, none typed",
                                        i, step_beats.size()));
            end else if (plan[i].check == ONE_BEAT &&
                         (step_beats.size() != 1 || step_beats[0].kind != plan[i].kind ||
                          step_beats[0].len != plan[i].len)) begin
                note_mismatch($sformatf("directed row %0d: model disagrees with typed verdict",
                                        i));
            end
        end

        // random traffic: reset settings first, then each written setting
        for (int p = 0; p <= 4; p++) begin
            if (p > 0) begin
                settle();
                write_reg(REG_ADDRESS, set_address[p - 1]);
                write_reg(REG_INFO_CTRL, set_info[p - 1]);
                write_reg(REG_DISC_CTRL, set_disc[p - 1]);
            end
            // one frame past the payload limit, under the first written setting
            if (p == 1) begin
                tx_calm = 1'b1;
                send_info_frame(LONG_PAYLOAD);
                send_line();
            end
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_random_unit();
        end

        settle();
        $display("%0d line bytes (%0d directed), %0d result beats checked",
                 bytes_sent, plan.size(), beats_seen);
        $display("%0d good frames, %0d bad frames, %0d disconnects, %0d register writes",
                 good_frames, bad_frames, disconnects, reg_writes);
        if (mismatch_count == 0 && awaited_beats.size() == 0) begin
            $display("PASS");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("FAIL");
        end
        $finish;
    end

endmodule
